/* hw/rtl/pto_pkg.sv */
`timescale 1ns / 1ps

package pto_pkg;

    localparam int DATA_W   = 32;
    localparam int REG_W    = 31;
    localparam int MODE_W   = 3;
    localparam int IDX_W    = 2;
    localparam int QUO_BITS = 34;
    localparam int OUT_W    = 40;

    localparam logic [MODE_W-1:0] MODE_PLAIN = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LASSO = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SCAD  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MCP   = 3'd3;

    localparam logic [IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LEVEL = 2'd1;
    localparam logic [IDX_W-1:0] CFG_SHAPE = 2'd2;
    localparam logic [IDX_W-1:0] CFG_EIGEN = 2'd3;

    localparam logic [REG_W-1:0] SHAPE_RESET = 31'd242483;
    localparam logic [REG_W-1:0] EIGEN_RESET = 31'd65536;

    typedef logic [63:0] wide_t;

endpackage

/* hw/rtl/penalized_threshold_operator_core.sv */
`timescale 1ns / 1ps

// channel   | ports                    | contents
// s_axis    | s_tvalid s_tready s_tdata | update_value
// m_axis    | m_tvalid m_tready m_tdata | coefficient, saturated
// config    | cfg_write cfg_index cfg_data | mode, lambda, alpha, eigenvalue
//
// 41 register stages: six setup stages, one stage per quotient bit of the
// 34-bit restoring divider, and the rounding and clipping output stage
// one item per cycle; the whole pipeline advances when the output register is
// empty or taken, so a stall freezes every stage in place
// rst_n clears the valid bits and loads the register defaults

module penalized_threshold_operator_core
    import pto_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [31:0] update_value
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // [31:0] coefficient, [32] saturated
    input  logic                cfg_write,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [REG_W-1:0]    cfg_data
);

    localparam logic [31:0] ONE  = 32'(64'(1) << FRAC_BITS);
    localparam wide_t       ONE2 = 64'(1) << (2 * FRAC_BITS);
    localparam int          SH   = QUO_BITS - FRAC_BITS;

    // configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [REG_W-1:0]  level_reg;
    logic [REG_W-1:0]  shape_reg;
    logic [REG_W-1:0]  eigen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            level_reg <= '0;
            shape_reg <= SHAPE_RESET;
            eigen_reg <= EIGEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_LEVEL: level_reg <= cfg_data;
                CFG_SHAPE: shape_reg <= cfg_data;
                CFG_EIGEN: eigen_reg <= cfg_data;
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // stage a: magnitude and lambda difference
    logic              a_vld_reg, a_un_reg, a_uz_reg, a_aneg_reg;
    logic [31:0]       a_raw_reg;
    logic [32:0]       a_u_reg, a_t_reg;
    logic [REG_W-1:0]  a_am_reg;
    logic [32:0]       u_next, t_next;

    assign u_next = s_tdata[31] ? (33'h1_0000_0000 - {1'b0, s_tdata}) : {1'b0, s_tdata};
    assign t_next = (u_next > 33'(level_reg)) ? (u_next - 33'(level_reg)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_raw_reg  <= s_tdata;
            a_un_reg   <= s_tdata[31];
            a_uz_reg   <= (s_tdata == '0);
            a_u_reg    <= u_next;
            a_t_reg    <= t_next;
            a_aneg_reg <= (32'(shape_reg) < ONE);
            a_am_reg   <= (32'(shape_reg) >= ONE) ? REG_W'(32'(shape_reg) - ONE)
                                                 : REG_W'(ONE - 32'(shape_reg));
        end
    end

    // stage b: products
    logic        b_vld_reg, b_un_reg, b_uz_reg, b_aneg_reg;
    logic [31:0] b_raw_reg;
    logic [32:0] b_u_reg, b_t_reg;
    logic [61:0] b_al_reg, b_amd_reg, b_da_reg;
    logic [63:0] b_amu_reg, b_ta_reg;
    logic [62:0] b_dl_reg;
    logic [31:0] d_plus_one;
    assign d_plus_one = 32'(eigen_reg) + ONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_raw_reg  <= a_raw_reg;
            b_un_reg   <= a_un_reg;
            b_uz_reg   <= a_uz_reg;
            b_aneg_reg <= a_aneg_reg;
            b_u_reg    <= a_u_reg;
            b_t_reg    <= a_t_reg;
            b_al_reg   <= 62'(shape_reg) * 62'(level_reg);
            b_amd_reg  <= 62'(a_am_reg) * 62'(eigen_reg);
            b_da_reg   <= 62'(eigen_reg) * 62'(shape_reg);
            b_amu_reg  <= 64'(a_am_reg) * 64'(a_u_reg);
            b_ta_reg   <= 64'(a_t_reg) * 64'(shape_reg);
            b_dl_reg   <= 63'(d_plus_one) * 63'(level_reg);
        end
    end

    // stage c: scad and mcp terms, low region test, split of a*lambda*d
    logic        c_vld_reg, c_un_reg, c_uz_reg, c_low_reg;
    logic        c_nneg_reg, c_qneg_reg, c_mqneg_reg;
    logic [31:0] c_raw_reg;
    logic [32:0] c_u_reg, c_t_reg;
    wide_t       c_nm_reg, c_qm_reg, c_mqm_reg, c_ta_reg;
    logic [61:0] c_ald_lo_reg, c_ald_hi_reg;
    wide_t       al_w, amd_w, da_w;
    assign al_w  = 64'(b_al_reg);
    assign amd_w = 64'(b_amd_reg);
    assign da_w  = 64'(b_da_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_raw_reg    <= b_raw_reg;
            c_un_reg     <= b_un_reg;
            c_uz_reg     <= b_uz_reg;
            c_u_reg      <= b_u_reg;
            c_t_reg      <= b_t_reg;
            c_ta_reg     <= b_ta_reg;
            c_low_reg    <= ((64'(b_u_reg) << FRAC_BITS) <= 64'(b_dl_reg));
            c_ald_lo_reg <= 62'(b_al_reg[30:0]) * 62'(eigen_reg);
            c_ald_hi_reg <= 62'(b_al_reg[61:31]) * 62'(eigen_reg);
            if (b_aneg_reg)
            begin
                c_nneg_reg <= 1'b1;
                c_nm_reg   <= b_amu_reg + al_w;
                c_qneg_reg <= 1'b1;
                c_qm_reg   <= amd_w + ONE2;
            end
            else
            begin
                c_nneg_reg <= (b_amu_reg < al_w);
                c_nm_reg   <= (b_amu_reg >= al_w) ? (b_amu_reg - al_w) : (al_w - b_amu_reg);
                c_qneg_reg <= (amd_w < ONE2);
                c_qm_reg   <= (amd_w >= ONE2) ? (amd_w - ONE2) : (ONE2 - amd_w);
            end
            c_mqneg_reg <= (da_w < ONE2);
            c_mqm_reg   <= (da_w >= ONE2) ? (da_w - ONE2) : (ONE2 - da_w);
        end
    end

    // stage d: a*lambda*d assembled
    logic        d_vld_reg, d_un_reg, d_uz_reg, d_low_reg;
    logic        d_nneg_reg, d_qneg_reg, d_mqneg_reg;
    logic [31:0] d_raw_reg;
    logic [32:0] d_u_reg, d_t_reg;
    wide_t       d_nm_reg, d_qm_reg, d_mqm_reg, d_ta_reg;
    logic [95:0] d_ald_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else if (en)
            d_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_raw_reg   <= c_raw_reg;
            d_un_reg    <= c_un_reg;
            d_uz_reg    <= c_uz_reg;
            d_low_reg   <= c_low_reg;
            d_u_reg     <= c_u_reg;
            d_t_reg     <= c_t_reg;
            d_nneg_reg  <= c_nneg_reg;
            d_qneg_reg  <= c_qneg_reg;
            d_mqneg_reg <= c_mqneg_reg;
            d_nm_reg    <= c_nm_reg;
            d_qm_reg    <= c_qm_reg;
            d_mqm_reg   <= c_mqm_reg;
            d_ta_reg    <= c_ta_reg;
            d_ald_reg   <= (96'(c_ald_hi_reg) << 31) + 96'(c_ald_lo_reg);
        end
    end

    // stage e: region select
    logic        e_vld_reg, e_neg_reg, e_uz_reg, e_pass_reg;
    logic [31:0] e_raw_reg;
    wide_t       e_num_reg, e_den_reg;
    logic        mid;
    wide_t       num_next, den_next;
    logic        neg_next;

    assign mid = ((96'(d_u_reg) << (2 * FRAC_BITS)) <= d_ald_reg);

    always_comb
    begin
        num_next = 64'(d_u_reg);
        den_next = 64'(eigen_reg);
        neg_next = d_un_reg;
        priority if (mode_reg == MODE_LASSO || (mode_reg == MODE_SCAD && d_low_reg))
        begin
            num_next = 64'(d_t_reg);
        end
        else if (mode_reg == MODE_SCAD && mid)
        begin
            num_next = d_nm_reg;
            den_next = d_qm_reg;
            neg_next = d_un_reg ^ d_nneg_reg ^ d_qneg_reg;
        end
        else if (mode_reg == MODE_MCP && mid)
        begin
            num_next = d_ta_reg;
            den_next = d_mqm_reg;
            neg_next = d_un_reg ^ d_mqneg_reg;
        end
        else
        begin
            num_next = 64'(d_u_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (en)
            e_vld_reg <= d_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_raw_reg  <= d_raw_reg;
            e_uz_reg   <= d_uz_reg;
            e_pass_reg <= mode_reg[2];
            e_num_reg  <= num_next;
            e_den_reg  <= den_next;
            e_neg_reg  <= neg_next;
        end
    end

    // stage f feeds the divider: quotient overflow test and top remainder
    logic        dv_vld_reg  [0:QUO_BITS];
    logic        dv_neg_reg  [0:QUO_BITS];
    logic        dv_uz_reg   [0:QUO_BITS];
    logic        dv_pass_reg [0:QUO_BITS];
    logic        dv_dz_reg   [0:QUO_BITS];
    logic        dv_ovf_reg  [0:QUO_BITS];
    logic        dv_nnz_reg  [0:QUO_BITS];
    logic [31:0] dv_raw_reg  [0:QUO_BITS];
    wide_t       dv_den_reg  [0:QUO_BITS];
    wide_t       dv_rem_reg  [0:QUO_BITS];
    logic [QUO_BITS-1:0] dv_low_reg [0:QUO_BITS];
    logic [QUO_BITS-1:0] dv_q_reg   [0:QUO_BITS];
    wide_t       top_next;
    logic        ovf_next;

    assign top_next = e_num_reg >> SH;
    assign ovf_next = (top_next >= e_den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (en)
            dv_vld_reg[0] <= e_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_neg_reg[0]  <= e_neg_reg;
            dv_uz_reg[0]   <= e_uz_reg;
            dv_pass_reg[0] <= e_pass_reg;
            dv_dz_reg[0]   <= (e_den_reg == '0);
            dv_ovf_reg[0]  <= ovf_next;
            dv_nnz_reg[0]  <= (e_num_reg != '0);
            dv_raw_reg[0]  <= e_raw_reg;
            dv_den_reg[0]  <= e_den_reg;
            dv_rem_reg[0]  <= ovf_next ? '0 : top_next;
            dv_low_reg[0]  <= QUO_BITS'(e_num_reg << FRAC_BITS);
            dv_q_reg[0]    <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_div
        localparam int BIT = QUO_BITS - 1 - k;
        logic [64:0] r2;
        logic        ge;
        assign r2 = {dv_rem_reg[k], dv_low_reg[k][BIT]};
        assign ge = (r2 >= 65'(dv_den_reg[k]));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[k+1] <= 1'b0;
            else if (en)
                dv_vld_reg[k+1] <= dv_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_neg_reg[k+1]  <= dv_neg_reg[k];
                dv_uz_reg[k+1]   <= dv_uz_reg[k];
                dv_pass_reg[k+1] <= dv_pass_reg[k];
                dv_dz_reg[k+1]   <= dv_dz_reg[k];
                dv_ovf_reg[k+1]  <= dv_ovf_reg[k];
                dv_nnz_reg[k+1]  <= dv_nnz_reg[k];
                dv_raw_reg[k+1]  <= dv_raw_reg[k];
                dv_den_reg[k+1]  <= dv_den_reg[k];
                dv_low_reg[k+1]  <= dv_low_reg[k];
                dv_rem_reg[k+1]  <= ge ? 64'(r2 - 65'(dv_den_reg[k])) : 64'(r2);
                dv_q_reg[k+1]    <= dv_q_reg[k] | (QUO_BITS'(ge) << BIT);
            end
        end
    end

    // rounding, clipping and sign
    logic [31:0] coef_reg;
    logic        sat_reg;
    logic        rnd, big;
    logic [QUO_BITS:0] mag;
    logic [31:0] coef_next;
    logic        sat_next;

    assign rnd = ({1'b0, dv_rem_reg[QUO_BITS], 1'b0} >= 66'(dv_den_reg[QUO_BITS]));

    always_comb
    begin
        mag       = {1'b0, dv_q_reg[QUO_BITS]} + (QUO_BITS+1)'(rnd);
        big       = dv_dz_reg[QUO_BITS] ? dv_nnz_reg[QUO_BITS] : dv_ovf_reg[QUO_BITS];
        sat_next  = dv_dz_reg[QUO_BITS];
        coef_next = '0;
        // zero denominator: quotient bits are meaningless
        if (dv_dz_reg[QUO_BITS])
        begin
            mag = '0;
        end
        if (dv_uz_reg[QUO_BITS])
        begin
            big = 1'b0;
            mag = '0;
        end
        if (dv_pass_reg[QUO_BITS])
        begin
            coef_next = dv_raw_reg[QUO_BITS];
            sat_next  = 1'b0;
        end
        else if (dv_neg_reg[QUO_BITS])
        begin
            if (big || mag > (QUO_BITS+1)'(33'h0_8000_0000))
            begin
                coef_next = 32'h8000_0000;
                sat_next  = 1'b1;
            end
            else
                coef_next = 32'(~mag + 1'b1);
        end
        else
        begin
            if (big || mag > (QUO_BITS+1)'(33'h0_7FFF_FFFF))
            begin
                coef_next = 32'h7FFF_FFFF;
                sat_next  = 1'b1;
            end
            else
                coef_next = 32'(mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dv_vld_reg[QUO_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg <= coef_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, sat_reg, coef_reg};

`ifndef NO_ASSERTIONS
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[QUO_BITS] && !dv_dz_reg[QUO_BITS] && !dv_ovf_reg[QUO_BITS]
        |-> dv_rem_reg[QUO_BITS] < dv_den_reg[QUO_BITS])
        else $error("divider remainder not below denominator");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a blocked output");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] && m_tdata[31:0] != 32'h7FFF_FFFF
        && m_tdata[31:0] != 32'h8000_0000 |-> m_tdata[31:0] == '0)
        else $error("saturated result not at full scale or zero");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import pto_pkg::*;

    localparam int FRAC = 16;
    localparam logic [127:0] MAG_LIMIT = 128'd1 << 33;
    localparam logic [2:0] MODE_UNUSED_4 = 3'd4;
    localparam logic [2:0] MODE_UNUSED_5 = 3'd5;
    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [REG_W-1:0]  lambda;
        logic [REG_W-1:0]  alpha;
        logic [REG_W-1:0]  eigen;
        logic [31:0]       update;
        bit                typed;
        logic [31:0]       coef;
        logic              sat;
    } stim_row_t;

    typedef struct {
        logic [31:0] coef;
        logic        sat;
    } coef_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_write;
    logic [IDX_W-1:0]   cfg_index;
    logic [REG_W-1:0]   cfg_data;

    logic [MODE_W-1:0]  cur_mode;
    logic [REG_W-1:0]   cur_lambda;
    logic [REG_W-1:0]   cur_alpha;
    logic [REG_W-1:0]   cur_eigen;

    coef_t       coef_queue[$];
    logic        typed_queue[$];
    coef_t       typed_value_queue[$];
    bit          next_typed;
    coef_t       next_typed_value;
    int          errors;
    int          accepted_out;
    int          sender_idle_pct;
    int          rcv_idle_pct;
    int          hold_left;
    bit          hold_done;
    stim_row_t   rows[$];

    penalized_threshold_operator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic coef_t finish_coef(logic [127:0] num, logic [127:0] den, bit neg,
                                          bit uz);
        logic [127:0] mag;
        logic [127:0] rem;
        coef_t r;
        r.sat = 1'b0;
        if (den == 0)
        begin
            r.sat = 1'b1;
            mag = (num == 0) ? 128'd0 : MAG_LIMIT;
        end
        else
        begin
            mag = (num << FRAC) / den;
            rem = (num << FRAC) % den;
            if (mag >= MAG_LIMIT)
                mag = MAG_LIMIT;
            else if (2 * rem >= den)
                mag = mag + 1;
        end
        if (uz)
            mag = 0;
        if (neg)
        begin
            if (mag > 128'h80000000)
            begin
                mag = 128'h80000000;
                r.sat = 1'b1;
            end
            r.coef = 32'(-mag);
        end
        else
        begin
            if (mag > 128'h7fffffff)
            begin
                mag = 128'h7fffffff;
                r.sat = 1'b1;
            end
            r.coef = mag[31:0];
        end
        return r;
    endfunction

    function automatic coef_t threshold_update(logic [31:0] raw);
        bit           un;
        bit           uz;
        bit           in_low;
        bit           in_mid;
        bit           aneg;
        bit           nneg;
        bit           qneg;
        logic [127:0] mag_u;
        logic [127:0] lam;
        logic [127:0] alp;
        logic [127:0] eig;
        logic [127:0] shrunk;
        logic [127:0] one;
        logic [127:0] one2;
        logic [127:0] am;
        logic [127:0] t1;
        logic [127:0] t2;
        logic [127:0] t3;
        logic [127:0] nm;
        logic [127:0] qm;
        coef_t r;
        un = raw[31];
        mag_u = un ? (128'd1 << 32) - raw : 128'(raw);
        lam = 128'(cur_lambda);
        alp = 128'(cur_alpha);
        eig = 128'(cur_eigen);
        one = 128'd1 << FRAC;
        one2 = 128'd1 << (2 * FRAC);
        shrunk = (mag_u > lam) ? mag_u - lam : 0;
        uz = (mag_u == 0);
        in_low = 0;
        in_mid = 0;
        if (cur_mode > MODE_MCP)
        begin
            r.coef = raw;
            r.sat = 1'b0;
            return r;
        end
        if (cur_mode == MODE_SCAD || cur_mode == MODE_MCP)
        begin
            in_mid = (mag_u << (2 * FRAC)) <= alp * lam * eig;
            in_low = (mag_u << FRAC) <= (eig + one) * lam;
        end
        if (cur_mode == MODE_LASSO || (cur_mode == MODE_SCAD && in_low))
            return finish_coef(shrunk, eig, un, uz);
        if (cur_mode == MODE_SCAD && in_mid)
        begin
            aneg = alp < one;
            am = aneg ? one - alp : alp - one;
            t1 = am * mag_u;
            t2 = alp * lam;
            t3 = am * eig;
            if (aneg)
            begin
                nneg = 1;
                nm = t1 + t2;
                qneg = 1;
                qm = t3 + one2;
            end
            else
            begin
                nneg = t1 < t2;
                nm = nneg ? t2 - t1 : t1 - t2;
                qneg = t3 < one2;
                qm = qneg ? one2 - t3 : t3 - one2;
            end
            return finish_coef(nm, qm, un ^ nneg ^ qneg, uz);
        end
        if (cur_mode == MODE_MCP && in_mid)
        begin
            qneg = eig * alp < one2;
            qm = qneg ? one2 - eig * alp : eig * alp - one2;
            return finish_coef(shrunk * alp, qm, un ^ qneg, uz);
        end
        return finish_coef(mag_u, eig, un, uz);
    endfunction

    // scoreboard
    always @(posedge clk)
    begin
        coef_t exp_c;
        coef_t typed_c;
        logic  is_typed;
        if (rst_n && s_tvalid && s_tready)
        begin
            coef_queue.insert(coef_queue.size(), threshold_update(s_tdata));
            typed_queue.insert(typed_queue.size(), next_typed);
            typed_value_queue.insert(typed_value_queue.size(), next_typed_value);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            accepted_out++;
            if (coef_queue.size() == 0)
            begin
                $error("unexpected item coefficient=%h", m_tdata[31:0]);
                errors++;
            end
            else
            begin
                exp_c = coef_queue.pop_front();
                is_typed = typed_queue.pop_front();
                typed_c = typed_value_queue.pop_front();
                if (is_typed)
                    exp_c = typed_c;
                if (m_tdata[31:0] !== exp_c.coef)
                begin
                    $error("coefficient expected %h actual %h", exp_c.coef, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[32] !== exp_c.sat)
                begin
                    $error("saturated expected %b actual %b", exp_c.sat, m_tdata[32]);
                    errors++;
                end
            end
        end
    end

    // receiver with one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_out >= 950)
        begin
            m_tready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else
            m_tready <= $urandom_range(0, 99) >= rcv_idle_pct;
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic drain();
        while (coef_queue.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic set_config(logic [MODE_W-1:0] mode, logic [REG_W-1:0] lambda,
                              logic [REG_W-1:0] alpha, logic [REG_W-1:0] eigen);
        drain();
        write_reg(CFG_MODE, REG_W'(mode));
        write_reg(CFG_LEVEL, lambda);
        write_reg(CFG_SHAPE, alpha);
        write_reg(CFG_EIGEN, eigen);
        cfg_write <= 1'b0;
        cur_mode = mode;
        cur_lambda = lambda;
        cur_alpha = alpha;
        cur_eigen = eigen;
    endtask

    task automatic send_item(logic [31:0] update);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= update;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_update();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(0, 31);
            2, 3: v = 32'((64'(cur_lambda) * $urandom_range(0, 12)) / 2)
                      + $urandom_range(0, 255) - 128;
            default: v = 0;
        endcase
        if ($urandom_range(0, 1) && $urandom_range(0, 4) != 2)
            v = -v;
        return v;
    endfunction

    function automatic logic [REG_W-1:0] random_reg(logic [REG_W-1:0] lo, int hi_bit);
        case ($urandom_range(0, 9))
            0: return 31'h7fffffff;
            1: return lo;
            2: return REG_W'($urandom);
            default: return REG_W'($urandom_range(32'(lo), 32'(1) << hi_bit));
        endcase
    endfunction

    function automatic void add_row(logic [MODE_W-1:0] mode, logic [REG_W-1:0] lambda,
                                    logic [REG_W-1:0] alpha, logic [REG_W-1:0] eigen,
                                    logic [31:0] update, bit typed, logic [31:0] coef,
                                    logic sat);
        stim_row_t r;
        r = '{mode, lambda, alpha, eigen, update, typed, coef, sat};
        rows.insert(rows.size(), r);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        accepted_out = 0;
        hold_left = 0;
        hold_done = 1'b0;
        next_typed = 1'b0;
        next_typed_value = '{32'd0, 1'b0};
        sender_idle_pct = 6;
        rcv_idle_pct = 81;
        cur_mode = MODE_PLAIN;
        cur_lambda = '0;
        cur_alpha = SHAPE_RESET;
        cur_eigen = EIGEN_RESET;

        add_row(MODE_PLAIN, 0, SHAPE_RESET, EIGEN_RESET, 32'h0, 1, 32'h0, 0);
        add_row(MODE_PLAIN, 0, SHAPE_RESET, EIGEN_RESET, 32'h7fffffff, 1, 32'h7fffffff, 0);
        add_row(MODE_PLAIN, 0, SHAPE_RESET, EIGEN_RESET, 32'h80000000, 1, 32'h80000000, 0);
        add_row(MODE_PLAIN, 0, SHAPE_RESET, EIGEN_RESET, 32'h10000, 1, 32'h10000, 0);
        add_row(MODE_PLAIN, 0, SHAPE_RESET, 1, 32'h7fffffff, 1, 32'h7fffffff, 1);
        add_row(MODE_PLAIN, 0, SHAPE_RESET, 1, 32'h80000000, 1, 32'h80000000, 1);
        add_row(MODE_PLAIN, 0, SHAPE_RESET, 31'h7fffffff, 32'h7fffffff, 0, 0, 0);
        add_row(MODE_LASSO, 31'h10000, SHAPE_RESET, 31'h10000, 32'h30000, 1, 32'h20000, 0);
        add_row(MODE_LASSO, 31'h10000, SHAPE_RESET, 31'h10000, 32'hfffd0000, 1,
                32'hfffe0000, 0);
        add_row(MODE_LASSO, 31'h10000, SHAPE_RESET, 31'h10000, 32'h8000, 1, 32'h0, 0);
        add_row(MODE_LASSO, 31'h7fffffff, SHAPE_RESET, 31'h10000, 32'h80000000, 0, 0, 0);
        add_row(MODE_SCAD, 31'h10000, SHAPE_RESET, 31'h10000, 32'h18000, 0, 0, 0);
        add_row(MODE_SCAD, 31'h10000, SHAPE_RESET, 31'h10000, 32'h30000, 0, 0, 0);
        add_row(MODE_SCAD, 31'h10000, SHAPE_RESET, 31'h10000, 32'h50000, 1, 32'h50000, 0);
        add_row(MODE_SCAD, 31'h10000, SHAPE_RESET, 31'h10000, 32'hfffd0000, 0, 0, 0);
        add_row(MODE_SCAD, 31'h20000, 31'h10000, 31'h10000, 32'h30000, 0, 0, 0);
        add_row(MODE_SCAD, 31'h10000, 31'h8000, 31'h10000, 32'h4000, 0, 0, 0);
        add_row(MODE_SCAD, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 32'h7fffffff, 0, 0, 0);
        add_row(MODE_MCP, 31'h10000, SHAPE_RESET, 31'h10000, 32'h20000, 0, 0, 0);
        add_row(MODE_MCP, 31'h10000, SHAPE_RESET, 31'h10000, 32'h0, 1, 32'h0, 0);
        add_row(MODE_MCP, 31'h10000, 31'h10000, 31'h10000, 32'h8000, 1, 32'h0, 1);
        add_row(MODE_MCP, 31'h10000, 31'h10000, 31'h10000, 32'hffff0000, 1, 32'h0, 1);
        add_row(MODE_MCP, 31'h10000, 31'h18000, 31'h8000, 32'h100, 0, 0, 0);
        add_row(MODE_UNUSED_4, 0, SHAPE_RESET, 31'h10000, 32'h80000000, 1, 32'h80000000, 0);
        add_row(MODE_UNUSED_5, 0, SHAPE_RESET, 31'h10000, 32'h12345678, 1, 32'h12345678, 0);
        add_row(MODE_UNUSED_6, 0, SHAPE_RESET, 31'h10000, 32'h0, 1, 32'h0, 0);
        add_row(MODE_UNUSED_7, 0, SHAPE_RESET, 31'h10000, 32'hffffffff, 1, 32'hffffffff, 0);

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed items, reset values apply to the first rows
        foreach (rows[i])
        begin
            if (rows[i].mode != cur_mode || rows[i].lambda != cur_lambda ||
                rows[i].alpha != cur_alpha || rows[i].eigen != cur_eigen)
            begin
                s_tvalid <= 1'b0;
                set_config(rows[i].mode, rows[i].lambda, rows[i].alpha, rows[i].eigen);
            end
            next_typed = rows[i].typed;
            next_typed_value = '{rows[i].coef, rows[i].sat};
            send_item(rows[i].update);
        end
        next_typed = 1'b0;

        // random items in blocks, one configuration per block
        for (int blk = 0; blk < 9; blk++)
        begin
            s_tvalid <= 1'b0;
            case (blk / 3)
                0: begin sender_idle_pct = 6; rcv_idle_pct = 81; end
                1: begin sender_idle_pct = 81; rcv_idle_pct = 6; end
                default: begin sender_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            set_config(MODE_W'($urandom_range(0, 7)),
                       (blk == 8) ? 31'h7fffffff : random_reg(0, 20),
                       ($urandom_range(0, 7) == 0) ? REG_W'($urandom_range(0, 65536))
                                                   : random_reg(31'd65537, 19),
                       random_reg(1, 18));
            for (int k = 0; k < 150; k++)
            begin
                if (k == 75 && blk == 4)
                begin
                    s_tvalid <= 1'b0;
                    while (coef_queue.size() != 0)
                        @(negedge clk);
                    @(negedge clk);
                end
                send_item(random_update());
            end
        end
        s_tvalid <= 1'b0;

        while (coef_queue.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("status: fail");
        $finish;
    end

endmodule

/* penalized_threshold_operator_core.f */
hw/rtl/pto_pkg.sv
hw/rtl/penalized_threshold_operator_core.sv
verif/testbench.sv
